// ===== src/dense_shortest_path_engine_unit_assert.svh =====
// assertion macros used by the port-level checker file
// no dependencies; clock and reset names are passed in by the user
`ifndef DENSE_SHORTEST_PATH_ENGINE_UNIT_ASSERT_SVH
`define DENSE_SHORTEST_PATH_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dsp_pkg.sv =====
// shared constants and types of the dense shortest path engine
// no dependencies
`default_nettype none

package dsp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int RESULT_LIMIT     = 64;

    localparam int IDX_BITS    = 6;
    localparam int CFG_BITS    = 7;
    localparam int IN_W_BITS   = 16;
    localparam int DIST_BITS   = 22;

    localparam logic [DIST_BITS-1:0] DIST_MAX     = '1;
    localparam logic [CFG_BITS-1:0]  VCOUNT_RESET = 7'd64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    // relaxation outcome of one matrix column
    typedef struct packed {
        logic                 upd;   // estimate improved, write back
        logic                 take;  // candidate for the next settled vertex
        logic [DIST_BITS-1:0] est;   // estimate after relaxation
    } t_relax;

endpackage

`default_nettype wire

// ===== src/dsp_weight_ram.sv =====
// weight matrix store: one write port, one registered read port
// uses no package
`default_nettype none

module dsp_weight_ram #(
    parameter int AW = 12,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/dsp_label_ram.sv =====
// per-vertex label store (distance and predecessor), registered read
// uses no package
`default_nettype none

module dsp_label_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 28
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/dsp_relax.sv =====
// relaxation of one edge: saturating add, compare, update decision
// depends on dsp_pkg
`default_nettype none

module dsp_relax #(
    parameter int WB = dsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                         i_valid,
    input  wire logic [WB-1:0]                i_weight,
    input  wire logic [dsp_pkg::DIST_BITS-1:0] i_cur_dist,
    input  wire logic [dsp_pkg::DIST_BITS-1:0] i_old_dist,
    input  wire logic                         i_reached,
    input  wire logic                         i_settled,
    output dsp_pkg::t_relax                   o_res
);

    localparam int DB = dsp_pkg::DIST_BITS;
    localparam int SW = ((WB > DB) ? WB : DB) + 1;

    logic [SW-1:0] w_sum;
    logic [DB-1:0] w_cand;
    logic          w_upd;

    assign w_sum  = SW'(i_cur_dist) + SW'(i_weight);
    assign w_cand = (w_sum > SW'(dsp_pkg::DIST_MAX)) ? dsp_pkg::DIST_MAX : w_sum[DB-1:0];

    // no edge or settled target: leave the label alone
    assign w_upd = i_valid && (i_weight != '0) && !i_settled
                   && (!i_reached || (w_cand < i_old_dist));

    always_comb begin
        o_res.upd  = w_upd;
        o_res.est  = w_upd ? w_cand : i_old_dist;
        o_res.take = i_valid && !i_settled && (i_reached || w_upd);
    end

endmodule

`default_nettype wire

// ===== src/dense_shortest_path_engine_unit.sv =====
// dense single-source shortest path engine, top level; uses dsp_pkg and the dsp_* modules
// a weight write is accepted back to back, busy stays low
// a run makes one round per settled vertex, then reads the labels out:
// each round is one sweep of a matrix row through the weight and label memory read ports
// results stream one per cycle at the end of a run and cannot be stalled
// reset clears control state and the flag vectors; weights and labels are not cleared
`default_nettype none

module dense_shortest_path_engine_unit #(
    parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_command,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_row,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_col,
    input  wire logic [dsp_pkg::IN_W_BITS-1:0] i_weight,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_source,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dsp_pkg::CFG_BITS-1:0]  i_cfg_data,
    // result channel
    output logic                               o_strobe,
    output logic [dsp_pkg::IDX_BITS-1:0]       o_vertex,
    output logic                               o_reachable,
    output logic [dsp_pkg::DIST_BITS-1:0]      o_distance,
    output logic [dsp_pkg::IDX_BITS-1:0]       o_predecessor,
    output logic                               o_is_source,
    output logic                               o_last
);

    // only the first 64 rows are addressable from the ports
    localparam int NLIM = (MAX_VERTICES < dsp_pkg::RESULT_LIMIT) ? MAX_VERTICES
                                                                 : dsp_pkg::RESULT_LIMIT;
    localparam int IW   = $clog2(NLIM);
    localparam int CW   = $clog2(NLIM + 1);
    localparam int DB   = dsp_pkg::DIST_BITS;
    localparam int LW   = DB + IW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RELAX,   // sweep the row of the current vertex
        S_SETTLE,  // last column of the sweep in the relax stage
        S_NEXT,    // settle the least-estimate vertex or finish
        S_EMIT,    // read labels out in index order
        S_DRAIN    // last beat on the result ports
    } t_state;

    t_state             r_state;
    logic [dsp_pkg::CFG_BITS-1:0] r_vcount;
    logic [CW-1:0]      r_j;
    logic [IW-1:0]      r_cur;
    logic [DB-1:0]      r_dcur;
    logic [IW-1:0]      r_src;
    logic               r_src_ok;
    logic [NLIM-1:0]    r_settled;
    logic [NLIM-1:0]    r_reached;

    // running minimum over the sweep
    logic               r_found;
    logic [DB-1:0]      r_least;
    logic [IW-1:0]      r_pick;

    // relax stage, aligned with the memory read data
    logic               r_s1_valid;
    logic [IW-1:0]      r_s1_j;

    // emit stage, aligned with the memory read data
    logic               r_e1_valid;
    logic [IW-1:0]      r_e1_v;
    logic               r_e1_last;
    logic               r_e1_reached;
    logic               r_e1_src;

    logic [CW-1:0]      w_n;
    logic [CW-1:0]      w_last_j;
    logic               w_j_last;
    logic [IW-1:0]      w_j_idx;
    logic               w_accept;
    logic               w_run;
    logic               w_src_ok;
    logic               w_wr_ok;

    logic [WEIGHT_BITS-1:0] w_wq;
    logic [LW-1:0]      w_lq;
    logic [DB-1:0]      w_lq_dist;
    logic [IW-1:0]      w_lq_prev;
    logic               w_l_we;
    logic [IW-1:0]      w_l_waddr;
    logic [LW-1:0]      w_l_wdata;

    dsp_pkg::t_relax    w_rlx;

    // vertices in use: zero counts as one, clipped at the store size
    always_comb begin
        if (r_vcount == '0) begin
            w_n = CW'(1);
        end else if (32'(r_vcount) > NLIM) begin
            w_n = CW'(NLIM);
        end else begin
            w_n = CW'(r_vcount);
        end
    end

    assign w_last_j = CW'(w_n - CW'(1));
    assign w_j_last = (r_j == w_last_j);
    assign w_j_idx  = r_j[IW-1:0];

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign w_accept = start && !busy;
    assign w_run    = w_accept && (i_command == dsp_pkg::CMD_RUN);
    assign w_src_ok = (32'(i_source) < 32'(w_n));
    assign w_wr_ok  = (32'(i_row) < NLIM) && (32'(i_col) < NLIM);

    // weight matrix, row-major with a power-of-two row pitch
    dsp_weight_ram #(
        .AW (2 * IW),
        .DW (WEIGHT_BITS)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_command == dsp_pkg::CMD_WRITE) && w_wr_ok),
        .i_waddr ({i_row[IW-1:0], i_col[IW-1:0]}),
        .i_wdata (WEIGHT_BITS'(i_weight)),
        .i_raddr ({r_cur, w_j_idx}),
        .o_rdata (w_wq)
    );

    // label write: source seeded at start, else relax stage write-back
    always_comb begin
        if (w_run) begin
            w_l_we    = w_src_ok;
            w_l_waddr = i_source[IW-1:0];
            w_l_wdata = {{DB{1'b0}}, i_source[IW-1:0]};
        end else begin
            w_l_we    = w_rlx.upd;
            w_l_waddr = r_s1_j;
            w_l_wdata = {w_rlx.est, r_cur};
        end
    end

    // labels are only ever read behind a reached flag, so no clearing is needed
    dsp_label_ram #(
        .DEPTH (NLIM),
        .AW    (IW),
        .DW    (LW)
    ) u_lram (
        .i_clk   (i_clk),
        .i_we    (w_l_we),
        .i_waddr (w_l_waddr),
        .i_wdata (w_l_wdata),
        .i_raddr (w_j_idx),
        .o_rdata (w_lq)
    );

    assign w_lq_dist = w_lq[LW-1:IW];
    assign w_lq_prev = w_lq[IW-1:0];

    // column j of a sweep never overlaps a read of the same entry: each column is
    // read once and written the next cycle, and the next sweep starts after S_NEXT
    dsp_relax #(
        .WB (WEIGHT_BITS)
    ) u_relax (
        .i_valid    (r_s1_valid),
        .i_weight   (w_wq),
        .i_cur_dist (r_dcur),
        .i_old_dist (w_lq_dist),
        .i_reached  (r_reached[r_s1_j]),
        .i_settled  (r_settled[r_s1_j]),
        .o_res      (w_rlx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= dsp_pkg::VCOUNT_RESET;
            r_j        <= '0;
            r_settled  <= '0;
            r_reached  <= '0;
            r_found    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_e1_valid <= 1'b0;
            r_src_ok   <= 1'b0;
        end else begin
            r_s1_valid <= 1'b0;
            r_e1_valid <= 1'b0;

            // relax stage: write-back flag and running minimum, lowest index on ties
            if (w_rlx.upd) begin
                r_reached[r_s1_j] <= 1'b1;
            end
            if (w_rlx.take && (!r_found || (w_rlx.est < r_least))) begin
                r_found <= 1'b1;
                r_least <= w_rlx.est;
                r_pick  <= r_s1_j;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_vcount <= i_cfg_data;
                    end
                    if (w_run) begin
                        r_settled <= '0;
                        r_reached <= '0;
                        r_found   <= 1'b0;
                        r_j       <= '0;
                        r_src     <= i_source[IW-1:0];
                        r_src_ok  <= w_src_ok;
                        r_cur     <= i_source[IW-1:0];
                        r_dcur    <= '0;
                        if (w_src_ok) begin
                            r_settled[i_source[IW-1:0]] <= 1'b1;
                            r_reached[i_source[IW-1:0]] <= 1'b1;
                            r_state <= S_RELAX;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_RELAX: begin
                    r_s1_valid <= 1'b1;
                    r_s1_j     <= w_j_idx;
                    if (w_j_last) begin
                        r_state <= S_SETTLE;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_SETTLE: begin
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                    if (r_found) begin
                        r_cur              <= r_pick;
                        r_dcur             <= r_least;
                        r_settled[r_pick]  <= 1'b1;
                        r_state            <= S_RELAX;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_e1_valid   <= 1'b1;
                    r_e1_v       <= w_j_idx;
                    r_e1_last    <= w_j_last;
                    r_e1_reached <= r_reached[w_j_idx];
                    r_e1_src     <= r_src_ok && (w_j_idx == r_src);
                    if (w_j_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result beat: emit stage plus label read data, masked for unreached vertices
    assign o_strobe      = r_e1_valid;
    assign o_vertex      = dsp_pkg::IDX_BITS'(r_e1_v);
    assign o_reachable   = r_e1_reached;
    assign o_distance    = r_e1_reached ? w_lq_dist : '0;
    assign o_predecessor = r_e1_reached ? dsp_pkg::IDX_BITS'(w_lq_prev) : '0;
    assign o_is_source   = r_e1_src;
    assign o_last        = r_e1_last;

endmodule

`default_nettype wire

// ===== src/dsp_checker.sv =====
// port-level checker of the shortest path engine, bound to the top level
// depends on dense_shortest_path_engine_unit_assert.svh
`default_nettype none

`include "dense_shortest_path_engine_unit_assert.svh"

module dsp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_command,
    input wire logic o_strobe,
    input wire logic o_last,
    input wire logic o_is_source,
    input wire logic o_reachable
);

    `DSP_ASSERT_NXT(a_run_busy, i_clk, i_rst_n, start && !busy && i_command, busy, "run not busy")
    `DSP_ASSERT_IMP(a_beat_busy, i_clk, i_rst_n, o_strobe, busy, "result beat while idle")
    `DSP_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_strobe && o_last, !o_strobe, "beat after last")
    `DSP_ASSERT_NXT(a_beats_gapless, i_clk, i_rst_n, o_strobe && !o_last, o_strobe, "gap in beats")
    `DSP_ASSERT_IMP(a_src_reach, i_clk, i_rst_n, o_strobe && o_is_source, o_reachable, "source unreached")

endmodule

bind dense_shortest_path_engine_unit dsp_checker u_dsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_command   (i_command),
    .o_strobe    (o_strobe),
    .o_last      (o_last),
    .o_is_source (o_is_source),
    .o_reachable (o_reachable)
);

`default_nettype wire

// ===== tb/dsp_path_checker.sv =====
// shortest path result checker: tracks weight writes and the vertex count, predicts each run
// and compares every result beat against the oldest prediction; depends on dsp_pkg only
`timescale 1ns / 1ps

module dsp_path_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic                          i_command,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_row,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_col,
    input  wire logic [dsp_pkg::IN_W_BITS-1:0] i_weight,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_source,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [dsp_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  wire logic                          i_strobe,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_vertex,
    input  wire logic                          i_reachable,
    input  wire logic [dsp_pkg::DIST_BITS-1:0] i_distance,
    input  wire logic [dsp_pkg::IDX_BITS-1:0]  i_predecessor,
    input  wire logic                          i_is_source,
    input  wire logic                          i_last,
    output int                                 o_failures,
    output int                                 o_pending,
    output int                                 o_checked
);
    import dsp_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;

    typedef struct packed {
        logic [IDX_BITS-1:0]  vertex;
        logic                 reachable;
        logic [DIST_BITS-1:0] distance;
        logic [IDX_BITS-1:0]  predecessor;
        logic                 is_source;
        logic                 last;
    } t_path_label;

    bit [IN_W_BITS-1:0] link_weight [NV][NV];
    bit [CFG_BITS-1:0]  vertex_count;
    t_path_label        expected_labels [$];

    function automatic int unsigned vertices_in_use();
        if (vertex_count == '0) return 1;
        if (32'(vertex_count) > NV) return NV;
        return 32'(vertex_count);
    endfunction

    // dense dijkstra, lowest index wins on equal estimates
    task automatic solve_paths(input bit [IDX_BITS-1:0] src);
        int unsigned        n;
        int unsigned        src_i;
        int unsigned        cur;
        int unsigned        pick;
        bit                 found;
        bit                 done [NV];
        bit                 seen [NV];
        bit [DIST_BITS-1:0] est [NV];
        bit [IDX_BITS-1:0]  prev [NV];
        bit [DIST_BITS-1:0] least;
        bit [DIST_BITS:0]   cand;
        t_path_label        lbl;
        n     = vertices_in_use();
        src_i = 32'(src);
        for (int j = 0; j < NV; j++) begin
            done[j] = 0;
            seen[j] = 0;
            est[j]  = '0;
            prev[j] = '0;
        end
        if (src_i < n) begin
            cur = src_i;
            done[cur] = 1;
            seen[cur] = 1;
            prev[cur] = src;
            do begin
                for (int j = 0; j < n; j++) begin
                    if (link_weight[cur][j] != '0 && !done[j]) begin
                        cand = {1'b0, est[cur]} + (DIST_BITS+1)'(link_weight[cur][j]);
                        if (cand > {1'b0, DIST_MAX}) cand = {1'b0, DIST_MAX};
                        if (!seen[j] || cand[DIST_BITS-1:0] < est[j]) begin
                            seen[j] = 1;
                            est[j]  = cand[DIST_BITS-1:0];
                            prev[j] = cur[IDX_BITS-1:0];
                        end
                    end
                end
                found = 0;
                pick  = 0;
                least = '0;
                for (int j = 0; j < n; j++) begin
                    if (seen[j] && !done[j] && (!found || est[j] < least)) begin
                        found = 1;
                        least = est[j];
                        pick  = j;
                    end
                end
                if (found) begin
                    cur = pick;
                    done[cur] = 1;
                end
            end while (found);
        end
        for (int v = 0; v < n; v++) begin
            lbl.vertex      = v[IDX_BITS-1:0];
            lbl.reachable   = seen[v];
            lbl.distance    = seen[v] ? est[v] : '0;
            lbl.predecessor = seen[v] ? prev[v] : '0;
            lbl.is_source   = (src_i < n) && (v == src_i);
            lbl.last        = (v + 1 == n);
            expected_labels = {expected_labels, lbl};
        end
    endtask

    task automatic compare_label();
        t_path_label want;
        t_path_label got;
        got = '{i_vertex, i_reachable, i_distance, i_predecessor, i_is_source, i_last};
        o_checked++;
        if (expected_labels.size() == 0) begin
            o_failures++;
            if (o_failures <= 10)
                $display("[%0t] result beat with nothing expected: vertex %0d dist %0d",
                         $realtime, got.vertex, got.distance);
            return;
        end
        want = expected_labels.pop_front();
        if (got.vertex !== want.vertex || got.reachable !== want.reachable ||
            got.distance !== want.distance || got.predecessor !== want.predecessor ||
            got.is_source !== want.is_source || got.last !== want.last) begin
            o_failures++;
            if (o_failures <= 10) begin
                $display("[%0t] mismatch exp v=%0d r=%0b d=%0d p=%0d s=%0b l=%0b",
                         $realtime, want.vertex, want.reachable, want.distance,
                         want.predecessor, want.is_source, want.last);
                $display("         act v=%0d r=%0b d=%0d p=%0d s=%0b l=%0b",
                         got.vertex, got.reachable, got.distance, got.predecessor,
                         got.is_source, got.last);
            end
        end
    endtask

    initial begin
        o_failures   = 0;
        o_pending    = 0;
        o_checked    = 0;
        vertex_count = VCOUNT_RESET;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_count = VCOUNT_RESET;
            expected_labels.delete();
        end else begin
            if (i_strobe) compare_label();
            if (i_cfg_valid && i_cfg_ready) vertex_count = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_command == CMD_WRITE) link_weight[i_row][i_col] = i_weight;
                else solve_paths(i_source);
            end
        end
        o_pending = expected_labels.size();
    end

endmodule

// ===== tb/tb_dense_shortest_path_engine_unit.sv =====
// top of the shortest path engine testbench: clock, reset, command and vertex-count stimulus
// and the verdict; depends on dsp_pkg, dense_shortest_path_engine_unit and dsp_path_checker
`timescale 1ns / 1ps

module tb_dense_shortest_path_engine_unit;
    import dsp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;    // block returns to idle right after the last beat
    localparam int DRAIN_CYCLES  = 20;
    localparam int TOTAL_ITEMS   = 220;
    localparam int SMALL_MAX     = 8;    // largest vertex count of the random phases

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_command;
    logic [IDX_BITS-1:0]  i_row;
    logic [IDX_BITS-1:0]  i_col;
    logic [IN_W_BITS-1:0] i_weight;
    logic [IDX_BITS-1:0]  i_source;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_BITS-1:0]  i_cfg_data;
    logic                 o_strobe;
    logic [IDX_BITS-1:0]  o_vertex;
    logic                 o_reachable;
    logic [DIST_BITS-1:0] o_distance;
    logic [IDX_BITS-1:0]  o_predecessor;
    logic                 o_is_source;
    logic                 o_last;

    int failures;
    int pending;
    int checked;

    int          cycles;
    int          calm_left;     // items left in a stretch without idle gaps
    int unsigned active_n;      // vertices in use under the current setting
    int          filled_n;      // side of the square block written so far
    int          writes_sent;
    int          runs_sent;
    int          settings_used;

    dense_shortest_path_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_weight      (i_weight),
        .i_source      (i_source),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_vertex      (o_vertex),
        .o_reachable   (o_reachable),
        .o_distance    (o_distance),
        .o_predecessor (o_predecessor),
        .o_is_source   (o_is_source),
        .o_last        (o_last)
    );

    // watches both channels and the result strobe, predicts and compares
    dsp_path_checker u_path_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_command     (i_command),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_weight      (i_weight),
        .i_source      (i_source),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_strobe      (o_strobe),
        .i_vertex      (o_vertex),
        .i_reachable   (o_reachable),
        .i_distance    (o_distance),
        .i_predecessor (o_predecessor),
        .i_is_source   (o_is_source),
        .i_last        (o_last),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or drops beats
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result beats still expected", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // idle gap ahead of a beat: mostly none or short, now and then long,
    // with occasional stretches of back-to-back beats
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
        roll = $urandom_range(0, 19);
        if (roll == 0) return $urandom_range(8, 40);
        if (roll <= 8) return $urandom_range(1, 3);
        return 0;
    endfunction

    // one command beat; returns right after the edge that took it
    task automatic issue(input logic cmd, input logic [IDX_BITS-1:0] row,
                         input logic [IDX_BITS-1:0] col, input logic [IN_W_BITS-1:0] w,
                         input logic [IDX_BITS-1:0] src);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            // noise on the payload while start is low
            start     <= 1'b0;
            i_command <= 1'($urandom);
            i_row     <= IDX_BITS'($urandom);
            i_col     <= IDX_BITS'($urandom);
            i_weight  <= IN_W_BITS'($urandom);
            i_source  <= IDX_BITS'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_row     <= row;
        i_col     <= col;
        i_weight  <= w;
        i_source  <= src;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_WRITE) writes_sent++;
        else runs_sent++;
    endtask

    task automatic write_weight(input int row, input int col, input int w);
        issue(CMD_WRITE, row[IDX_BITS-1:0], col[IDX_BITS-1:0], w[IN_W_BITS-1:0],
              IDX_BITS'($urandom));
    endtask

    task automatic run_from(input int src);
        issue(CMD_RUN, IDX_BITS'($urandom), IDX_BITS'($urandom), IN_W_BITS'($urandom),
              src[IDX_BITS-1:0]);
    endtask

    // drop start, wait for every predicted beat, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // vertex-count write, only ever called with the block idle
    task automatic set_vertex_count(input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[CFG_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CFG_BITS'($urandom);
        // zero counts as one vertex, anything past the store as all of it
        if (value == 0) active_n = 1;
        else if (value > MAX_VERTICES_DEF) active_n = MAX_VERTICES_DEF;
        else active_n = value;
        settings_used++;
    endtask

    // one row written in full: only a self loop, so a run from that vertex
    // settles nothing else and reads no other row
    task automatic fill_row(input int r);
        for (int c = 0; c < MAX_VERTICES_DEF; c++) begin
            write_weight(r, c, (c == r) ? int'($urandom_range(1, 65535)) : 0);
        end
    endtask

    // write every entry of the k by k block not yet written, so no run under
    // a count of k can touch an unwritten weight
    task automatic cover_block(input int k);
        int w;
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < k; c++) begin
                if (r >= filled_n || c >= filled_n) begin
                    if ($urandom_range(0, 2) == 0) w = $urandom_range(1, 64);
                    else w = 0;
                    write_weight(r, c, w);
                end
            end
        end
        if (k > filled_n) filled_n = k;
    endtask

    // one random beat: mostly writes into the vertices in use, runs from valid
    // sources, with some stray writes and out-of-range sources mixed in
    task automatic random_item();
        int row;
        int col;
        int w;
        int roll;
        if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 9) == 0) run_from($urandom_range(0, 63));
            else run_from($urandom_range(0, active_n - 1));
        end else begin
            row  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, active_n - 1)
                                                : $urandom_range(0, 63);
            col  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, active_n - 1)
                                                : $urandom_range(0, 63);
            roll = $urandom_range(0, 9);
            if (roll <= 1) w = 0;
            else if (roll == 2) w = 16'hFFFF;
            else if (roll == 3) w = $urandom_range(0, 65535);
            else w = $urandom_range(1, 64);
            write_weight(row, col, w);
        end
    endtask

    initial begin
        int phase_len;
        int setting;
        int left;

        calm_left     = 0;
        active_n      = MAX_VERTICES_DEF;
        filled_n      = 0;
        writes_sent   = 0;
        runs_sent     = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_command     = CMD_WRITE;
        i_row         = '0;
        i_col         = '0;
        i_weight      = '0;
        i_source      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full-width run at the reset vertex count from the last vertex
        fill_row(63);
        run_from(63);
        wait_idle();

        // count beyond the store clamps to the full matrix
        set_vertex_count(127);
        run_from(63);
        wait_idle();

        // a count of zero means a single vertex; source 1 is then out of range
        set_vertex_count(0);
        cover_block(active_n);
        run_from(0);
        run_from(1);
        wait_idle();

        // small graph: equal estimates on vertices 1 and 2, a removed edge,
        // a self loop, a max weight back edge and a write outside the in-use block
        set_vertex_count(4);
        cover_block(active_n);
        write_weight(0, 1, 5);
        write_weight(0, 2, 5);
        write_weight(0, 3, 0);
        write_weight(1, 3, 1);
        write_weight(2, 3, 1);
        write_weight(3, 3, 7);
        write_weight(1, 0, 16'hFFFF);
        write_weight(40, 41, 16'h1234);
        run_from(0);
        run_from(3);
        run_from(4);
        run_from(63);
        wait_idle();

        // random phases under changing small vertex counts
        while (writes_sent + runs_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       setting = 0;
                1:       setting = 1;
                2:       setting = 2;
                default: setting = $urandom_range(3, SMALL_MAX);
            endcase
            set_vertex_count(setting);
            cover_block(active_n);
            left      = TOTAL_ITEMS - writes_sent - runs_sent;
            phase_len = $urandom_range(15, 30);
            if (phase_len > left) phase_len = left;
            repeat (phase_len) random_item();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d weight writes and %0d runs over %0d vertex-count settings",
                 writes_sent, runs_sent, settings_used);
        $display("checked %0d vertex result beats, %0d failures", checked, failures);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
